FILE: design/irpde_pkg.sv
package irpde_pkg;

   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_START_MARK  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SPACE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MARK    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_SPACE   = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MARK   = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_SPACE  = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARK    = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_END_SPACE   = 8'd7;

   localparam logic [CFG_W-1:0] RST_START_MARK  = 16'd256;
   localparam logic [CFG_W-1:0] RST_START_SPACE = 16'd128;
   localparam logic [CFG_W-1:0] RST_ONE_MARK    = 16'd16;
   localparam logic [CFG_W-1:0] RST_ONE_SPACE   = 16'd16;
   localparam logic [CFG_W-1:0] RST_ZERO_MARK   = 16'd16;
   localparam logic [CFG_W-1:0] RST_ZERO_SPACE  = 16'd48;
   localparam logic [CFG_W-1:0] RST_END_MARK    = 16'd16;
   localparam logic [CFG_W-1:0] RST_END_SPACE   = 16'd16;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] start_mark;
      logic [CFG_W-1:0] start_space;
      logic [CFG_W-1:0] one_mark;
      logic [CFG_W-1:0] one_space;
      logic [CFG_W-1:0] zero_mark;
      logic [CFG_W-1:0] zero_space;
      logic [CFG_W-1:0] end_mark;
      logic [CFG_W-1:0] end_space;
   } cfg_type;

   typedef struct packed {
      logic level;
      logic busy_res;
      logic rejected;
      logic done_res;
   } rsp_type;

endpackage

FILE: design/irpde_step.sv
module irpde_step #(
   parameter int PAYLOAD_BITS = 32,
   parameter int IDX_W        = 7
) (
   input  logic                    req_type,
   input  logic [31:0]             code,
   input  irpde_pkg::cfg_type      cfg,
   input  logic [PAYLOAD_BITS-1:0] payload,
   input  logic [IDX_W-1:0]        chunk_idx,
   input  logic [15:0]             ticks,
   input  logic                    active,
   output logic [PAYLOAD_BITS-1:0] payload_nx,
   output logic [IDX_W-1:0]        chunk_idx_nx,
   output logic [15:0]             ticks_nx,
   output logic                    active_nx,
   output irpde_pkg::rsp_type      rsp
);
   import irpde_pkg::*;

   localparam int TOTAL_CHUNKS = 2 * PAYLOAD_BITS + 4;
   localparam int POS_W        = $clog2(PAYLOAD_BITS);
   localparam logic [IDX_W-1:0] TOTAL_IDX = IDX_W'(TOTAL_CHUNKS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TOTAL_CHUNKS - 1);
   localparam logic [IDX_W-1:0] ENDM_IDX  = IDX_W'(TOTAL_CHUNKS - 2);
   localparam logic [IDX_W-1:0] MSB_POS   = IDX_W'(PAYLOAD_BITS - 1);

   logic [PAYLOAD_BITS+31:0] code_ext;
   logic                     send_ok;
   logic                     rejected;
   logic [15:0]              ticks_dec;
   logic [IDX_W-1:0]         idx_inc;
   logic [IDX_W-1:0]         idx_m2;
   logic [IDX_W-1:0]         bit_pos;
   logic                     cur_bit;
   logic [15:0]              dur_next;
   logic                     done;

   assign code_ext = {{PAYLOAD_BITS{1'b0}}, code};
   assign send_ok  = (req_type == REQ_SEND) && !active;
   assign rejected = (req_type == REQ_SEND) && active;
   assign ticks_dec = ticks - 16'd1;
   assign idx_inc   = chunk_idx + IDX_W'(1);

   // duration of the chunk that follows the current one
   assign idx_m2  = idx_inc - IDX_W'(2);
   assign bit_pos = MSB_POS - {1'b0, idx_m2[IDX_W-1:1]};
   assign cur_bit = payload[bit_pos[POS_W-1:0]];

   always_comb begin
      if (idx_inc == ENDM_IDX) begin
         dur_next = cfg.end_mark;
      end else if (idx_inc == LAST_IDX) begin
         dur_next = cfg.end_space;
      end else if (idx_inc == IDX_W'(1)) begin
         dur_next = cfg.start_space;
      end else if (cur_bit) begin
         dur_next = idx_inc[0] ? cfg.one_space : cfg.one_mark;
      end else begin
         dur_next = idx_inc[0] ? cfg.zero_space : cfg.zero_mark;
      end
   end

   always_comb begin
      payload_nx   = payload;
      chunk_idx_nx = chunk_idx;
      ticks_nx     = ticks;
      active_nx    = active;
      done         = 1'b0;
      if (send_ok) begin
         payload_nx   = code_ext[PAYLOAD_BITS-1:0];
         chunk_idx_nx = '0;
         ticks_nx     = cfg.start_mark;
         active_nx    = 1'b1;
      end else if (req_type == REQ_TICK && active) begin
         ticks_nx = ticks_dec;
         if (ticks_dec == 16'd0) begin
            if (idx_inc >= TOTAL_IDX) begin
               chunk_idx_nx = TOTAL_IDX;
               active_nx    = 1'b0;
               done         = 1'b1;
            end else begin
               chunk_idx_nx = idx_inc;
               ticks_nx     = dur_next;
            end
         end
      end
   end

   assign rsp.level    = active_nx && (chunk_idx_nx < TOTAL_IDX) && !chunk_idx_nx[0];
   assign rsp.busy_res = active_nx;
   assign rsp.rejected = rejected;
   assign rsp.done_res = done;

endmodule

FILE: design/ir_pulse_distance_encoder_top.sv
// a result is registered, in the output stage or in the skid, as its request beat is accepted
// throughput: one request per cycle while req_ready is high; a two-entry result buffer (output + skid)
// keeps req_ready high while one result waits on rsp_ready
// reset: synchronous, active high; frame idle, no result valid, timing registers at defaults
module ir_pulse_distance_encoder_top #(
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [31:0]                       req_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_rejected,
   output logic                              rsp_done_res,
   input  logic                              csr_we,
   input  logic [irpde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [irpde_pkg::CFG_W-1:0]       csr_wdata
);
   import irpde_pkg::*;

   localparam int TOTAL_CHUNKS = 2 * PAYLOAD_BITS + 4;
   localparam int IDX_W        = $clog2(TOTAL_CHUNKS + 1);

   cfg_type                 cfg_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic [PAYLOAD_BITS-1:0] payload_in;
   logic [IDX_W-1:0]        chunk_idx_ff;
   logic [IDX_W-1:0]        chunk_idx_in;
   logic [15:0]             ticks_ff;
   logic [15:0]             ticks_in;
   logic                    active_ff;
   logic                    active_in;
   rsp_type                 rsp_new;
   rsp_type                 out_ff;
   rsp_type                 skid_ff;
   logic                    out_vld_ff;
   logic                    skid_vld_ff;
   logic                    req_fire;
   logic                    rsp_fire;

   assign req_ready = !skid_vld_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_vld_ff && rsp_ready;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_mark  <= RST_START_MARK;
         cfg_ff.start_space <= RST_START_SPACE;
         cfg_ff.one_mark    <= RST_ONE_MARK;
         cfg_ff.one_space   <= RST_ONE_SPACE;
         cfg_ff.zero_mark   <= RST_ZERO_MARK;
         cfg_ff.zero_space  <= RST_ZERO_SPACE;
         cfg_ff.end_mark    <= RST_END_MARK;
         cfg_ff.end_space   <= RST_END_SPACE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_MARK:  cfg_ff.start_mark  <= csr_wdata;
            CSR_START_SPACE: cfg_ff.start_space <= csr_wdata;
            CSR_ONE_MARK:    cfg_ff.one_mark    <= csr_wdata;
            CSR_ONE_SPACE:   cfg_ff.one_space   <= csr_wdata;
            CSR_ZERO_MARK:   cfg_ff.zero_mark   <= csr_wdata;
            CSR_ZERO_SPACE:  cfg_ff.zero_space  <= csr_wdata;
            CSR_END_MARK:    cfg_ff.end_mark    <= csr_wdata;
            CSR_END_SPACE:   cfg_ff.end_space   <= csr_wdata;
            default: ;
         endcase
      end
   end

   irpde_step #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX_W        (IDX_W)
   ) u_step (
      .req_type     (req_type),
      .code         (req_code),
      .cfg          (cfg_ff),
      .payload      (payload_ff),
      .chunk_idx    (chunk_idx_ff),
      .ticks        (ticks_ff),
      .active       (active_ff),
      .payload_nx   (payload_in),
      .chunk_idx_nx (chunk_idx_in),
      .ticks_nx     (ticks_in),
      .active_nx    (active_in),
      .rsp          (rsp_new)
   );

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff   <= '0;
         chunk_idx_ff <= IDX_W'(TOTAL_CHUNKS);
         ticks_ff     <= '0;
         active_ff    <= 1'b0;
      end else if (req_fire) begin
         payload_ff   <= payload_in;
         chunk_idx_ff <= chunk_idx_in;
         ticks_ff     <= ticks_in;
         active_ff    <= active_in;
      end
   end

   // result buffer: output stage plus skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_fire) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= req_fire;
         end
      end else if (req_fire) begin
         if (out_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (req_fire) begin
            out_ff <= rsp_new;
         end
      end else if (req_fire) begin
         if (out_vld_ff) begin
            skid_ff <= rsp_new;
         end else begin
            out_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_level    = out_ff.level;
   assign rsp_busy_res = out_ff.busy_res;
   assign rsp_rejected = out_ff.rejected;
   assign rsp_done_res = out_ff.done_res;

endmodule

FILE: tb/tb_ir_pulse_distance_encoder_top.sv
`timescale 1ns / 1ps

module tb_ir_pulse_distance_encoder_top;
   import irpde_pkg::*;

   localparam int NBITS = 32;
   localparam int CHUNKS = 2 * NBITS + 4;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic        kind;
      logic [31:0] code;
   } req_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_type = REQ_TICK;
   logic [31:0]          req_code = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_level;
   logic                 rsp_busy_res;
   logic                 rsp_rejected;
   logic                 rsp_done_res;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   ir_pulse_distance_encoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_code     (req_code),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_level    (rsp_level),
      .rsp_busy_res (rsp_busy_res),
      .rsp_rejected (rsp_rejected),
      .rsp_done_res (rsp_done_res),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // timing registers as the block should hold them
   logic [CFG_W-1:0] dur_reg [8] = '{RST_START_MARK, RST_START_SPACE, RST_ONE_MARK,
                                     RST_ONE_SPACE, RST_ZERO_MARK, RST_ZERO_SPACE,
                                     RST_END_MARK, RST_END_SPACE};

   // frame state
   logic [31:0]      frame_code = '0;
   int unsigned      chunk = CHUNKS;
   logic [CFG_W-1:0] ticks_left = '0;
   logic             frame_on = 1'b0;

   req_beat_type req_beats [$];
   rsp_type      envelope_q [$];
   req_beat_type next_beat;
   rsp_type      want_env;

   int errors = 0;
   int unsigned queued_beats = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [CFG_W-1:0] chunk_ticks(int unsigned c, logic [31:0] code);
      int unsigned k;
      logic one;
      if (c == 0) begin
         chunk_ticks = dur_reg[CSR_START_MARK[2:0]];
      end else if (c == 1) begin
         chunk_ticks = dur_reg[CSR_START_SPACE[2:0]];
      end else if (c == CHUNKS - 2) begin
         chunk_ticks = dur_reg[CSR_END_MARK[2:0]];
      end else if (c == CHUNKS - 1) begin
         chunk_ticks = dur_reg[CSR_END_SPACE[2:0]];
      end else begin
         k = (c - 2) / 2;
         one = code[NBITS - 1 - k];
         if (c % 2 == 0) begin
            chunk_ticks = one ? dur_reg[CSR_ONE_MARK[2:0]] : dur_reg[CSR_ZERO_MARK[2:0]];
         end else begin
            chunk_ticks = one ? dur_reg[CSR_ONE_SPACE[2:0]] : dur_reg[CSR_ZERO_SPACE[2:0]];
         end
      end
   endfunction

   function automatic void advance_frame(logic kind, logic [31:0] code);
      rsp_type r;
      r = '0;
      if (kind == REQ_SEND) begin
         if (frame_on) begin
            r.rejected = 1'b1;
         end else begin
            frame_code = code;
            chunk = 0;
            ticks_left = chunk_ticks(0, code);
            frame_on = 1'b1;
         end
      end else if (frame_on) begin
         ticks_left = ticks_left - CFG_W'(1);
         if (ticks_left == 0) begin
            chunk++;
            if (chunk >= CHUNKS) begin
               chunk = CHUNKS;
               frame_on = 1'b0;
               r.done_res = 1'b1;
            end else begin
               ticks_left = chunk_ticks(chunk, frame_code);
            end
         end
      end
      r.level = frame_on && (chunk < CHUNKS) && (chunk % 2 == 0);
      r.busy_res = frame_on;
      envelope_q.push_back(r);
   endfunction

   function automatic int unsigned frame_ticks(logic [31:0] code);
      int unsigned span;
      logic [CFG_W-1:0] d;
      span = 0;
      for (int unsigned c = 0; c < CHUNKS; c++) begin
         d = chunk_ticks(c, code);
         span += (d == 0) ? 65536 : d;
      end
      return span;
   endfunction

   function automatic void push_beat(logic kind, logic [31:0] code);
      req_beat_type b;
      b.kind = kind;
      b.code = code;
      req_beats.push_back(b);
      queued_beats++;
   endfunction

   function automatic void queue_frame(logic [31:0] code, int unsigned reject_pct,
                                       bit busy_send);
      int unsigned span;
      span = frame_ticks(code);
      push_beat(REQ_SEND, code);
      if (busy_send) push_beat(REQ_SEND, ~code);
      for (int unsigned i = 0; i < span; i++) begin
         push_beat(REQ_TICK, $urandom);
         if (i + 1 < span && $urandom_range(99) < reject_pct) push_beat(REQ_SEND, $urandom);
      end
   endfunction

   function automatic logic [31:0] pick_code();
      case ($urandom_range(7))
         0: pick_code = '0;
         1: pick_code = '1;
         default: pick_code = $urandom;
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] rand_ticks();
      if ($urandom_range(7) == 0) rand_ticks = CFG_W'($urandom_range(1, 12));
      else rand_ticks = CFG_W'($urandom_range(1, 3));
   endfunction

   function automatic void gen_traffic(int unsigned beats);
      int unsigned stop;
      logic [31:0] code;
      stop = queued_beats + beats;
      while (queued_beats < stop) begin
         code = pick_code();
         case ($urandom_range(19))
            0: push_beat(REQ_TICK, code);
            1: push_beat(REQ_SEND, code);
            2: begin
               // frame cut short, the next frames land on it while busy
               push_beat(REQ_SEND, code);
               repeat ($urandom_range(1, frame_ticks(code) - 1)) push_beat(REQ_TICK, $urandom);
            end
            3: repeat ($urandom_range(1, 4)) push_beat(REQ_TICK, $urandom);
            default: queue_frame(code, 3, $urandom_range(9) == 0);
         endcase
      end
   endfunction

   function automatic void set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      while (req_beats.size() != 0 || req_valid || envelope_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= CSR_END_SPACE) dur_reg[idx[2:0]] = val;
   endtask

   task automatic program_timing(logic [CFG_W-1:0] sm, logic [CFG_W-1:0] ss,
                                 logic [CFG_W-1:0] om, logic [CFG_W-1:0] os,
                                 logic [CFG_W-1:0] zm, logic [CFG_W-1:0] zs,
                                 logic [CFG_W-1:0] em, logic [CFG_W-1:0] es);
      wait_idle();
      write_reg(CSR_START_MARK, sm);
      write_reg(CSR_START_SPACE, ss);
      write_reg(CSR_ONE_MARK, om);
      write_reg(CSR_ONE_SPACE, os);
      write_reg(CSR_ZERO_MARK, zm);
      write_reg(CSR_ZERO_SPACE, zs);
      write_reg(CSR_END_MARK, em);
      write_reg(CSR_END_SPACE, es);
      // unmapped index, must leave timing alone
      write_reg(CSR_IDX_W'($urandom_range(CSR_END_SPACE + 1, 255)), CFG_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void check_bit(string what, logic want, logic got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0b actual %0b", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) advance_frame(req_type, req_code);
         if (!req_valid || req_ready) begin
            if (req_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_beat = req_beats.pop_front();
               req_valid <= 1'b1;
               req_type <= next_beat.kind;
               req_code <= next_beat.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (envelope_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none actual %b%b%b%b",
                        $time, rsp_level, rsp_busy_res, rsp_rejected, rsp_done_res);
            end else begin
               want_env = envelope_q.pop_front();
               check_bit("level", want_env.level, rsp_level);
               check_bit("busy_res", want_env.busy_res, rsp_busy_res);
               check_bit("rejected", want_env.rejected, rsp_rejected);
               check_bit("done_res", want_env.done_res, rsp_done_res);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timing: idle tick, send while busy, start chunks, one zero bit, one one bit
      set_idling(0, 0);
      push_beat(REQ_TICK, 32'hFFFF_FFFF);
      push_beat(REQ_SEND, 32'h4000_0000);
      push_beat(REQ_SEND, 32'hFFFF_FFFF);
      repeat (479) push_beat(REQ_TICK, $urandom);

      // rest of that frame on short bit chunks, end chunks still at reset values
      wait_idle();
      for (int r = 0; r < 6; r++) write_reg(CSR_IDX_W'(r), CFG_W'(1));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      repeat (110) push_beat(REQ_TICK, $urandom);

      // shortest chunks, code extremes back to back
      program_timing(1, 1, 1, 1, 1, 1, 1, 1);
      queue_frame(32'h0000_0000, 0, 1'b1);
      queue_frame(32'hFFFF_FFFF, 0, 1'b0);
      queue_frame(32'h8000_0000, 0, 1'b0);
      queue_frame(32'h0000_0001, 0, 1'b0);
      push_beat(REQ_TICK, $urandom);

      for (int m = 0; m < 4; m++) begin
         program_timing(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
                        rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
         case (m)
            0: set_idling(0, 0);
            1: set_idling(51, 0);
            2: set_idling(0, 51);
            default: set_idling(10, 10);
         endcase
         if (m == 1) begin
            gen_traffic(50);
            wait_idle();
            gen_traffic(50);
         end else begin
            gen_traffic(100);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
